/* hw/rtl/cpls_pkg.sv */
`default_nettype none

package cpls_pkg;

	// field and register widths
	localparam int unsigned POS_W   = 16;
	localparam int unsigned ABS_W   = 18;  // signed absolute coordinate
	localparam int unsigned MAG_W   = 17;  // magnitude of an absolute coordinate
	localparam int unsigned SQ_W    = 2 * MAG_W;
	localparam int unsigned RAD_W   = 36;  // sum of two squares
	localparam int unsigned LEN_W   = 18;  // cord length, root width
	localparam int unsigned REM_W   = LEN_W + 2;
	localparam int unsigned CFG_W   = 18;
	localparam int unsigned CFG_IDX_W = 3;

	// root unit: one result bit per cycle
	localparam int unsigned ISQRT_STEPS = RAD_W / 2;
	localparam int unsigned CNT_W       = $clog2(ISQRT_STEPS + 1);

	localparam int unsigned IN_W  = 32;
	localparam int unsigned OUT_W = 80;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOME_X       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOME_Y       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LEFT_HOME    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RIGHT_HOME   = 3'd4;

	// reset values
	localparam logic [POS_W-1:0] BASE_LENGTH_RST = 16'd6604;
	localparam logic [POS_W-1:0] HOME_X_RST      = 16'd2268;
	localparam logic [POS_W-1:0] HOME_Y_RST      = 16'd1997;
	localparam logic [LEN_W-1:0] LEFT_HOME_RST   = 18'd3023;
	localparam logic [LEN_W-1:0] RIGHT_HOME_RST  = 18'd4774;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAG,
		ST_MUL,
		ST_LOAD,
		ST_ROOT,
		ST_DONE
	} state_t;

endpackage

`default_nettype wire

/* hw/rtl/cpls_isqrt.sv */
`default_nettype none

// Floor square root, restoring method, two radicand bits per cycle.
module cpls_isqrt
	import cpls_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [RAD_W-1:0] radicand,
	output logic                  done,
	output logic [LEN_W-1:0]      root
);

	logic [RAD_W-1:0] rad_q;
	logic [REM_W-1:0] rem_q;
	logic [LEN_W-1:0] root_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;

	logic             busy;
	logic [REM_W+1:0] rem_sh;
	logic [REM_W+1:0] trial;
	logic             ge;
	logic [REM_W+1:0] rem_nx;

	assign busy   = (cnt_q != '0);
	assign rem_sh = {rem_q, rad_q[RAD_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = (rem_sh >= trial);
	assign rem_nx = ge ? (rem_sh - trial) : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy && (cnt_q == CNT_W'(1));
			if (start) begin
				cnt_q <= CNT_W'(ISQRT_STEPS);
			end else if (busy) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= rem_nx[REM_W-1:0];   // remainder stays at or below 2*root
			root_q <= {root_q[LEN_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(ISQRT_STEPS))
		else $error("isqrt step count out of range");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("isqrt restarted while busy");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(cnt_q) == CNT_W'(1)))
		else $error("isqrt done without final step");

endmodule

`default_nettype wire

/* hw/rtl/cable_plotter_length_stepper.sv */
`default_nettype none

// Channel   Dir  Width  Contents
// s_*       in   32     target word: target_x, target_y
// m_*       out  80     step word: dirs, counts, new cord lengths
// cfg_*     in   18     register writes, no read-back
//
// From accept to m_tvalid an item passes these steps in order: adding the home
// offset, the magnitudes, the 17x17 squares, loading the radicands, the
// bit-serial root units, and forming the step words.
// The root units are the longest step: one root bit per cycle.
// s_tready is high only in idle, so a new target is taken only once the
// last one has left ST_DONE; a finished word parks in the output register,
// so the next target is taken while it waits for m_tready.
// Reset loads the cord lengths with the home length reset values; writes to
// the home length registers do not touch the stored lengths.
module cable_plotter_length_stepper
	import cpls_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [IN_W-1:0]      s_tdata,   // target_x[15:0], target_y[31:16]

	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	// left_dir[0], left_count[18:1], right_dir[19], right_count[37:20],
	// left_length_out[55:38], right_length_out[73:56], zero pad [79:74]
	output logic [OUT_W-1:0]          m_tdata,

	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	// configuration
	logic [POS_W-1:0] base_q;
	logic [POS_W-1:0] home_x_q;
	logic [POS_W-1:0] home_y_q;

	// the home length registers only matter at reset, where their reset
	// values are used, so writes to them are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= BASE_LENGTH_RST;
			home_x_q <= HOME_X_RST;
			home_y_q <= HOME_Y_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_LENGTH: base_q   <= cfg_data[POS_W-1:0];
				REG_HOME_X:      home_x_q <= cfg_data[POS_W-1:0];
				REG_HOME_Y:      home_y_q <= cfg_data[POS_W-1:0];
				REG_LEFT_HOME:   ;
				REG_RIGHT_HOME:  ;
				default:         ;
			endcase
		end
	end

	// sequencer
	state_t    state_q, state_nx;
	logic      accept;
	logic      mag_en;
	logic      mul_en;
	logic      out_load;
	logic      lroot_start, rroot_start;
	logic      lroot_done, rroot_done;

	logic m_tvalid_q;
	logic out_free;

	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx    = state_q;
		accept      = 1'b0;
		mag_en      = 1'b0;
		mul_en      = 1'b0;
		out_load    = 1'b0;
		lroot_start = 1'b0;
		rroot_start = 1'b0;
		s_tready    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					accept   = 1'b1;
					state_nx = ST_MAG;
				end
			end
			ST_MAG: begin
				mag_en   = 1'b1;
				state_nx = ST_MUL;
			end
			ST_MUL: begin
				mul_en   = 1'b1;
				state_nx = ST_LOAD;
			end
			ST_LOAD: begin
				lroot_start = 1'b1;
				rroot_start = 1'b1;
				state_nx    = ST_ROOT;
			end
			ST_ROOT: begin
				if (lroot_done) begin
					state_nx = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// absolute position, then magnitudes, then squares
	logic signed [ABS_W-1:0] x_q, y_q;
	logic signed [ABS_W-1:0] rx;
	logic [MAG_W-1:0]        xm_q, ym_q, rxm_q;
	logic [SQ_W-1:0]         xsq_q, ysq_q, rxsq_q;

	function automatic logic [MAG_W-1:0] mag(input logic signed [ABS_W-1:0] v);
		logic [ABS_W-1:0] a;
		a = v[ABS_W-1] ? (~v + ABS_W'(1)) : v;
		return a[MAG_W-1:0];
	endfunction

	assign rx = $signed({2'b00, base_q}) - x_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q <= $signed({{2{s_tdata[POS_W-1]}}, s_tdata[POS_W-1:0]})
				+ $signed({2'b00, home_x_q});
			y_q <= $signed({{2{s_tdata[IN_W-1]}}, s_tdata[IN_W-1:POS_W]})
				+ $signed({2'b00, home_y_q});
		end
		if (mag_en) begin
			xm_q  <= mag(x_q);
			ym_q  <= mag(y_q);
			rxm_q <= mag(rx);
		end
		if (mul_en) begin
			xsq_q  <= xm_q * xm_q;
			ysq_q  <= ym_q * ym_q;
			rxsq_q <= rxm_q * rxm_q;
		end
	end

	// root units
	logic [RAD_W-1:0] lrad, rrad;
	logic [LEN_W-1:0] lnew, rnew;

	assign lrad = {2'b00, xsq_q} + {2'b00, ysq_q};
	assign rrad = {2'b00, rxsq_q} + {2'b00, ysq_q};

	cpls_isqrt u_lroot (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (lroot_start),
		.radicand (lrad),
		.done     (lroot_done),
		.root     (lnew)
	);

	cpls_isqrt u_rroot (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (rroot_start),
		.radicand (rrad),
		.done     (rroot_done),
		.root     (rnew)
	);

	// step counts against stored lengths
	logic [LEN_W-1:0] left_len_q, right_len_q;
	logic             lshort, rshort;
	logic [LEN_W-1:0] lcnt, rcnt;

	assign lshort = (lnew < left_len_q);
	assign rshort = (rnew < right_len_q);
	assign lcnt   = lshort ? (left_len_q - lnew) : (lnew - left_len_q);
	assign rcnt   = rshort ? (right_len_q - rnew) : (rnew - right_len_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_len_q  <= LEFT_HOME_RST;
			right_len_q <= RIGHT_HOME_RST;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (out_load) begin
				left_len_q  <= lnew;
				right_len_q <= rnew;
				m_tvalid_q  <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q  <= 1'b0;
			end
		end
	end

	logic [OUT_W-1:0] out_q;

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= {6'b0, rnew, lnew, rcnt, rshort, lcnt, lshort};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_q;

	// both roots run in lockstep
	a_roots_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		lroot_done == rroot_done)
		else $error("root units out of step");

	// a shortening move always has a nonzero count
	a_left_short_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tdata[18:1] != '0))
		else $error("left shorten with zero count");

	a_right_short_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[19]) |-> (m_tdata[37:20] != '0))
		else $error("right shorten with zero count");

	// stored lengths follow the word just issued
	a_len_track: assert property (@(posedge clk) disable iff (!arst_n)
		$past(out_load) |-> (left_len_q == m_tdata[55:38]
			&& right_len_q == m_tdata[73:56]))
		else $error("stored lengths differ from issued word");

endmodule

`default_nettype wire
